// ----- design/lrb_pkg.sv -----
package lrb_pkg;

    // Width of every input coordinate, angle and the difference vector
    localparam int unsigned COORD_W = 16;
    localparam int unsigned DIFF_W  = COORD_W + 1;
    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned DIST_W  = 17;

    // Entries held in the arctangent table
    localparam int unsigned ATAN_ENTRIES = 24;

    // 1/1.6467602 in Q0.30
    localparam int unsigned GAIN_W = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

    // Largest range that the distance field reports
    localparam logic [DIST_W-1:0] DIST_MAX = 17'd92682;

    // Left half plane starts the angle at a half turn
    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // Control data that rides alongside the CORDIC vector
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [COORD_W-1:0] heading;
        logic               zero;
    } side_t;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- design/lrb_in_if.sv -----
interface lrb_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [15:0] landmark_x;
    logic signed [15:0] landmark_y;

    modport source (
        output valid, robot_x, robot_y, robot_heading, landmark_x, landmark_y,
        input  ready
    );

    modport sink (
        input  valid, robot_x, robot_y, robot_heading, landmark_x, landmark_y,
        output ready
    );
endinterface

// ----- design/lrb_out_if.sv -----
interface lrb_out_if;
    logic               valid;
    logic               ready;
    logic        [16:0] distance;
    logic signed [15:0] bearing;

    modport source (
        output valid, distance, bearing,
        input  ready
    );

    modport sink (
        input  valid, distance, bearing,
        output ready
    );
endinterface

// ----- design/landmark_range_bearing.sv -----
// Range and bearing from a robot pose to a landmark.
// Channel query carries one pose (robot_x, robot_y, robot_heading) and one
// landmark position (landmark_x, landmark_y) per beat; channel answer returns
// one beat per query with distance (unsigned Q17.0) and bearing (binary angle
// relative to the heading, wrapped modulo a full turn), in query order.
// A query passes through registers in order: one for the difference and
// half-plane fold, one per micro-rotation, one for the gain multiply and one
// for rounding and saturation. A new query is taken every cycle while the
// answer is not held; every stage is a register with its own valid bit.
// Reset clears all valid bits, so the pipeline comes up empty; data registers
// are left as they are. When the receiver holds ready low, the answer beat is
// held and stages fill up behind it: bubbles close up first, and query.ready
// drops only once every stage holds a beat. Nothing is dropped or repeated.
module landmark_range_bearing #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    lrb_in_if.sink   query,
    lrb_out_if.source answer
);
    import lrb_pkg::*;

    // Micro-rotations applied; the table bounds the count
    localparam int STAGES = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    // Difference vector plus guard bits plus two bits of CORDIC growth
    localparam int WIDTH  = DIFF_W + FRAC_BITS + 2;

    // Boundary k sits between stage k-1 and stage k; boundary 0 leaves the
    // front end and boundary STAGES feeds the back end.
    logic                    vld [STAGES+1];
    logic                    rdy [STAGES+1];
    logic signed [WIDTH-1:0] x_b [STAGES+1];
    logic signed [WIDTH-1:0] y_b [STAGES+1];
    side_t                   s_b [STAGES+1];

    // Form the difference vector and fold it into the right half plane
    lrb_pre #(
        .WIDTH     (WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_pre (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (query.valid),
        .in_ready      (query.ready),
        .robot_x       (query.robot_x),
        .robot_y       (query.robot_y),
        .robot_heading (query.robot_heading),
        .landmark_x    (query.landmark_x),
        .landmark_y    (query.landmark_y),
        .out_valid     (vld[0]),
        .out_ready     (rdy[0]),
        .x             (x_b[0]),
        .y             (y_b[0]),
        .side          (s_b[0])
    );

    // One micro-rotation per register stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        lrb_stage #(
            .WIDTH (WIDTH),
            .SHIFT (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_x      (x_b[k]),
            .in_y      (y_b[k]),
            .in_side   (s_b[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_x     (x_b[k+1]),
            .out_y     (y_b[k+1]),
            .out_side  (s_b[k+1])
        );
    end

    // Correct the gain, round, saturate and hold the answer beat
    lrb_post #(
        .WIDTH     (WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld[STAGES]),
        .in_ready  (rdy[STAGES]),
        .in_x      (x_b[STAGES]),
        .in_side   (s_b[STAGES]),
        .out_valid (answer.valid),
        .out_ready (answer.ready),
        .distance  (answer.distance),
        .bearing   (answer.bearing)
    );

    // The final y component is spent: the angle already records the rotation
    logic unused_y;
    assign unused_y = ^y_b[STAGES];

endmodule

// ----- design/lrb_pre.sv -----
module lrb_pre #(
    parameter int WIDTH     = 27,
    parameter int FRAC_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    robot_x,
    input  logic signed [15:0]    robot_y,
    input  logic signed [15:0]    robot_heading,
    input  logic signed [15:0]    landmark_x,
    input  logic signed [15:0]    landmark_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [WIDTH-1:0] x,
    output logic signed [WIDTH-1:0] y,
    output lrb_pkg::side_t        side
);
    import lrb_pkg::*;

    logic                    valid_reg;
    logic                    advance;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [WIDTH-1:0] dx_scaled;
    logic signed [WIDTH-1:0] dy_scaled;
    logic signed [WIDTH-1:0] x_reg;
    logic signed [WIDTH-1:0] x_next;
    logic signed [WIDTH-1:0] y_reg;
    logic signed [WIDTH-1:0] y_next;
    side_t                   side_reg;
    side_t                   side_next;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        dx        = {landmark_x[15], landmark_x} - {robot_x[15], robot_x};
        dy        = {landmark_y[15], landmark_y} - {robot_y[15], robot_y};
        dx_scaled = WIDTH'(dx) <<< FRAC_BITS;
        dy_scaled = WIDTH'(dy) <<< FRAC_BITS;
        // fold the left half plane onto the right one
        if (dx[DIFF_W-1])
        begin
            x_next          = -dx_scaled;
            y_next          = -dy_scaled;
            side_next.angle = HALF_TURN;
        end
        else
        begin
            x_next          = dx_scaled;
            y_next          = dy_scaled;
            side_next.angle = '0;
        end
        side_next.heading = robot_heading;
        side_next.zero    = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign x         = x_reg;
    assign y         = y_reg;
    assign side      = side_reg;

endmodule

// ----- design/lrb_stage.sv -----
module lrb_stage #(
    parameter int WIDTH = 27,
    parameter int SHIFT = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [WIDTH-1:0] in_x,
    input  logic signed [WIDTH-1:0] in_y,
    input  lrb_pkg::side_t          in_side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [WIDTH-1:0] out_x,
    output logic signed [WIDTH-1:0] out_y,
    output lrb_pkg::side_t          out_side
);
    import lrb_pkg::*;

    localparam logic [ANGLE_W-1:0] ATAN = atan_turn(5'(SHIFT));

    logic                    valid_reg;
    logic                    advance;
    logic signed [WIDTH-1:0] sx;
    logic signed [WIDTH-1:0] sy;
    logic signed [WIDTH-1:0] x_reg;
    logic signed [WIDTH-1:0] x_next;
    logic signed [WIDTH-1:0] y_reg;
    logic signed [WIDTH-1:0] y_next;
    side_t                   side_reg;
    side_t                   side_next;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        sx        = in_x >>> SHIFT;
        sy        = in_y >>> SHIFT;
        side_next = in_side;
        // rotate towards the x axis
        if (!in_y[WIDTH-1])
        begin
            x_next          = in_x + sy;
            y_next          = in_y - sx;
            side_next.angle = in_side.angle + ATAN;
        end
        else
        begin
            x_next          = in_x - sy;
            y_next          = in_y + sx;
            side_next.angle = in_side.angle - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_side  = side_reg;

endmodule

// ----- design/lrb_post.sv -----
module lrb_post #(
    parameter int WIDTH     = 27,
    parameter int FRAC_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [WIDTH-1:0] in_x,
    input  lrb_pkg::side_t          in_side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [16:0]             distance,
    output logic signed [15:0]      bearing
);
    import lrb_pkg::*;

    localparam int PW = WIDTH + GAIN_W;

    logic                  mul_valid_reg;
    logic                  res_valid_reg;
    logic                  mul_advance;
    logic                  res_advance;
    logic [WIDTH-2:0]      x_clamped;
    logic [ANGLE_W-1:0]    angle;
    logic [ANGLE_W-1:0]    angle_rounded;
    logic [PW-1:0]         prod_reg;
    logic [PW-1:0]         prod_next;
    logic [COORD_W-1:0]    bear_reg;
    logic [COORD_W-1:0]    bear_next;
    logic                  zero_reg;
    logic [PW-1:0]         rounded;
    logic [PW-1:0]         quotient;
    logic [DIST_W-1:0]     dist_reg;
    logic [DIST_W-1:0]     dist_next;
    logic [COORD_W-1:0]    bear_out_reg;

    assign res_advance = !res_valid_reg || out_ready;
    assign mul_advance = !mul_valid_reg || res_advance;
    assign in_ready    = mul_advance;

    // gain correction and bearing
    always_comb
    begin
        x_clamped     = in_x[WIDTH-1] ? '0 : in_x[WIDTH-2:0];
        prod_next     = PW'(x_clamped) * PW'(GAIN_Q30);
        angle         = in_side.zero ? '0 : in_side.angle;
        angle_rounded = angle + 32'h0000_8000;
        bear_next     = angle_rounded[ANGLE_W-1:ANGLE_W-COORD_W] - in_side.heading;
    end

    // round half up, then saturate; a zero difference gives distance zero
    always_comb
    begin
        rounded  = prod_reg + (PW'(1) << (29 + FRAC_BITS));
        quotient = rounded >> (30 + FRAC_BITS);
        if (zero_reg)
        begin
            dist_next = '0;
        end
        else if (quotient > PW'(DIST_MAX))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = quotient[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_advance)
            begin
                mul_valid_reg <= in_valid;
            end
            if (res_advance)
            begin
                res_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_advance && in_valid)
        begin
            prod_reg <= prod_next;
            bear_reg <= bear_next;
            zero_reg <= in_side.zero;
        end
        if (res_advance && mul_valid_reg)
        begin
            dist_reg     <= dist_next;
            bear_out_reg <= bear_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign distance  = dist_reg;
    assign bearing   = bear_out_reg;

endmodule
